// ----- rtl/dwl_pkg.sv -----
// ----------------------------------------------------------------------------
// dwl_pkg
// Shared types and constants of the DAWG word lookup block.
// ----------------------------------------------------------------------------
package dwl_pkg;

  // Graph geometry. EDGE_COUNT may be anything from 2 up to 2**FIELD_W.
  // SYMBOL_BITS may be 2 up to SYM_FIELD_W.
  localparam int EDGE_COUNT  = 65536;
  localparam int SYMBOL_BITS = 5;

  // Fixed widths of the word fields.
  localparam int FIELD_W     = 16;
  localparam int SYM_FIELD_W = 5;

  localparam int MEM_AW      = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
  localparam int PTR_W       = FIELD_W + 1;  // sibling walk may step past the top
  localparam int SCAN_LIMIT  = 2 ** SYMBOL_BITS;
  localparam int CNT_W       = SYMBOL_BITS;
  localparam int EDGE_W      = FIELD_W + 2 + SYMBOL_BITS;

  // Input tdata layout, lowest bit first.
  localparam int IN_ADDR_LSB   = 0;
  localparam int IN_TGT_LSB    = IN_ADDR_LSB + FIELD_W;
  localparam int IN_LAST_BIT   = IN_TGT_LSB + FIELD_W;
  localparam int IN_FINAL_BIT  = IN_LAST_BIT + 1;
  localparam int IN_SYM_LSB    = IN_FINAL_BIT + 1;
  localparam int IN_START_BIT  = IN_SYM_LSB + SYM_FIELD_W;
  localparam int IN_SNODE_LSB  = IN_START_BIT + 1;
  localparam int IN_USED_W     = IN_SNODE_LSB + FIELD_W;
  localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout: node, found, is_word.
  localparam int OUT_USED_W    = FIELD_W + 2;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_USED_W;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } cmd_op_e;

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_NODE,
    WALK_SCAN
  } walk_state_e;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] sym;
    logic                   final_flag;
    logic                   last_flag;
    logic [FIELD_W-1:0]     target;
  } edge_t;

  typedef struct packed {
    cmd_op_e            op;
    logic [FIELD_W-1:0] addr;
    edge_t              edge_word;   // sym field doubles as lookup symbol
    logic               start;
    logic [FIELD_W-1:0] start_node;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_link_t;

  typedef struct packed {
    logic               is_word;
    logic               found;
    logic [FIELD_W-1:0] node;
  } result_t;

endpackage

// ----- rtl/dwl_front.sv -----
// ----------------------------------------------------------------------------
// dwl_front
// Accepts input words, decodes them into commands and queues them for the
// graph walker.
// ----------------------------------------------------------------------------
module dwl_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [dwl_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                           s_axis_tuser_i,
  output dwl_pkg::cmd_link_t             link_o,
  input  logic                           pop_i
);

  dwl_pkg::cmd_t                    cmd_in;
  dwl_pkg::cmd_t                    fifo_q [dwl_pkg::QUEUE_DEPTH];
  logic [dwl_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [dwl_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [dwl_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                             push;
  logic                             pop;

  // decode
  always_comb begin
    cmd_in.op                   = s_axis_tuser_i ? dwl_pkg::OP_LOOKUP : dwl_pkg::OP_WRITE;
    cmd_in.addr                 = s_axis_tdata_i[dwl_pkg::IN_ADDR_LSB +: dwl_pkg::FIELD_W];
    cmd_in.edge_word.target     = s_axis_tdata_i[dwl_pkg::IN_TGT_LSB +: dwl_pkg::FIELD_W];
    cmd_in.edge_word.last_flag  = s_axis_tdata_i[dwl_pkg::IN_LAST_BIT];
    cmd_in.edge_word.final_flag = s_axis_tdata_i[dwl_pkg::IN_FINAL_BIT];
    cmd_in.edge_word.sym        = s_axis_tdata_i[dwl_pkg::IN_SYM_LSB +: dwl_pkg::SYMBOL_BITS];
    cmd_in.start                = s_axis_tdata_i[dwl_pkg::IN_START_BIT];
    cmd_in.start_node           = s_axis_tdata_i[dwl_pkg::IN_SNODE_LSB +: dwl_pkg::FIELD_W];
  end

  assign s_axis_tready_o = (count_q != dwl_pkg::QCNT_W'(dwl_pkg::QUEUE_DEPTH));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = pop_i && (count_q != '0);

  assign link_o.valid = (count_q != '0);
  assign link_o.cmd   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == dwl_pkg::QPTR_W'(dwl_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == dwl_pkg::QPTR_W'(dwl_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ----- rtl/dwl_back.sv -----
// ----------------------------------------------------------------------------
// dwl_back
// Edge memory and graph walker: carries out edge writes and symbol lookups,
// one memory read per cycle while it walks, and holds the result word until taken.
// ----------------------------------------------------------------------------
module dwl_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dwl_pkg::cmd_link_t              link_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [dwl_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic [dwl_pkg::EDGE_W-1:0]  edge_mem_q [dwl_pkg::EDGE_COUNT];
  logic [dwl_pkg::EDGE_W-1:0]  rdata_q;
  logic                        mem_we;
  logic [dwl_pkg::MEM_AW-1:0]  mem_waddr;
  logic                        mem_re;
  logic [dwl_pkg::MEM_AW-1:0]  mem_raddr;
  logic [31:0]                 rd_addr;

  dwl_pkg::walk_state_e        state_q, state_d;
  logic [dwl_pkg::FIELD_W-1:0] cur_q, cur_d;
  logic                        miss_q, miss_d;
  logic [dwl_pkg::PTR_W-1:0]   p_q, p_d;
  logic [dwl_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [dwl_pkg::SYMBOL_BITS-1:0] sym_q, sym_d;
  logic                        oor_q, oor_d;
  logic                        m_valid_q, m_valid_d;
  dwl_pkg::result_t            m_data_q, m_data_d;

  dwl_pkg::edge_t              edge_w;
  dwl_pkg::cmd_t               cmd;
  logic                        out_free;
  logic                        is_write;
  logic                        lookup_go;
  logic [dwl_pkg::FIELD_W-1:0] start_cur;
  logic                        start_miss;
  logic                        no_child;
  logic                        hit;
  logic                        scan_end;

  assign cmd      = link_i.cmd;
  // out-of-range reads give an all-zero edge
  assign edge_w   = oor_q ? '0 : dwl_pkg::edge_t'(rdata_q);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign is_write = link_i.valid && (cmd.op == dwl_pkg::OP_WRITE);
  assign lookup_go = link_i.valid && (cmd.op == dwl_pkg::OP_LOOKUP) && out_free;
  assign start_cur  = cmd.start ? cmd.start_node : cur_q;
  assign start_miss = cmd.start ? 1'b0 : miss_q;
  assign no_child   = (edge_w.target == '0);
  assign hit        = (edge_w.sym == sym_q);
  assign scan_end   = edge_w.last_flag || (cnt_q == dwl_pkg::CNT_W'(dwl_pkg::SCAN_LIMIT - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dwl_pkg::WALK_IDLE: begin
        if (lookup_go && !start_miss) begin
          state_d = dwl_pkg::WALK_NODE;
        end
      end
      dwl_pkg::WALK_NODE: begin
        state_d = no_child ? dwl_pkg::WALK_IDLE : dwl_pkg::WALK_SCAN;
      end
      dwl_pkg::WALK_SCAN: begin
        if (hit || scan_end) begin
          state_d = dwl_pkg::WALK_IDLE;
        end
      end
      default: state_d = dwl_pkg::WALK_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = dwl_pkg::MEM_AW'(cmd.addr);
    mem_re    = 1'b0;
    rd_addr   = '0;
    cur_d     = cur_q;
    miss_d    = miss_q;
    p_d       = p_q;
    cnt_d     = cnt_q;
    sym_d     = sym_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;

    unique case (state_q)
      dwl_pkg::WALK_IDLE: begin
        if (is_write) begin
          pop_o  = 1'b1;
          mem_we = (32'(cmd.addr) < 32'(dwl_pkg::EDGE_COUNT));
        end else if (lookup_go) begin
          pop_o  = 1'b1;
          sym_d  = cmd.edge_word.sym;
          cur_d  = start_cur;
          miss_d = start_miss;
          if (start_miss) begin
            m_valid_d = 1'b1;
            m_data_d  = '0;
          end else begin
            mem_re  = 1'b1;
            rd_addr = 32'(start_cur);
          end
        end
      end
      dwl_pkg::WALK_NODE: begin
        if (no_child) begin
          cur_d     = '0;
          miss_d    = 1'b1;
          m_valid_d = 1'b1;
          m_data_d  = '0;
        end else begin
          p_d     = dwl_pkg::PTR_W'(edge_w.target);
          cnt_d   = '0;
          mem_re  = 1'b1;
          rd_addr = 32'(edge_w.target);
        end
      end
      dwl_pkg::WALK_SCAN: begin
        if (hit) begin
          cur_d            = dwl_pkg::FIELD_W'(p_q);
          m_valid_d        = 1'b1;
          m_data_d.node    = dwl_pkg::FIELD_W'(p_q);
          m_data_d.found   = 1'b1;
          m_data_d.is_word = edge_w.final_flag;
        end else if (scan_end) begin
          cur_d     = '0;
          miss_d    = 1'b1;
          m_valid_d = 1'b1;
          m_data_d  = '0;
        end else begin
          p_d     = p_q + 1'b1;
          cnt_d   = cnt_q + 1'b1;
          mem_re  = 1'b1;
          rd_addr = 32'(p_q) + 32'd1;
        end
      end
      default: ;
    endcase
  end

  assign mem_raddr = dwl_pkg::MEM_AW'(rd_addr);
  assign oor_d     = mem_re ? (rd_addr >= 32'(dwl_pkg::EDGE_COUNT)) : oor_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      edge_mem_q[mem_waddr] <= {cmd.edge_word};
    end
    if (mem_re) begin
      rdata_q <= edge_mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dwl_pkg::WALK_IDLE;
      cur_q     <= '0;
      miss_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      miss_q    <= miss_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    cnt_q    <= cnt_d;
    sym_q    <= sym_d;
    oor_q    <= oor_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{dwl_pkg::OUT_PAD_W{1'b0}}, m_data_q};

endmodule

// ----- rtl/dawg_word_lookup_top.sv -----
// ----------------------------------------------------------------------------
// dawg_word_lookup_top
// DAWG dictionary walker: edge-write words load the graph, symbol words
// step through it and return the node reached.
//
//   port group   dir  handshake              contents
//   s_axis       in   tvalid/tready          edge write or symbol lookup
//   m_axis       out  tvalid/tready          node, found, is_word per lookup
//
// A write is done by the walker while idle. A lookup reads the current node's
// edge, then scans the sibling edges at its target: none when the node has no
// children, else 1 to 32. A sticky miss answers without a memory read.
// The walker does one edge memory read per cycle while it walks a lookup.
// A two-word queue takes input while the walker is busy or a result waits.
// Reset clears the current node and the miss flag; the edge memory keeps
// whatever it held and must be written before it is walked.
// ----------------------------------------------------------------------------
module dawg_word_lookup_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // edge_address[15:0], edge_target[31:16], edge_last[32], edge_final[33],
  // symbol[38:34], start_req[39], start_node[55:40]
  input  logic [dwl_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // node[15:0], found[16], is_word[17], zero pad above
  output logic [dwl_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  dwl_pkg::cmd_link_t link;
  logic               pop;

  dwl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .link_o          (link),
    .pop_i           (pop)
  );

  dwl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .link_i          (link),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
